// File: rtl/core/dlfr_pkg.sv
// package: constants, types and helper functions for the display list fog rewriter
`default_nettype none
package dlfr_pkg;
    localparam int MAX_DEPTH  = 12;
    localparam int STEP_LIMIT = 200000;
    localparam int MEM_BYTES  = 8388608;
    localparam int SEGMENTS   = 16;

    localparam int OFF_W   = 23;
    localparam int STEP_W  = 18;
    localparam int DEPTH_W = 4;
    localparam int SEG_W   = 4;
    localparam int STK_W   = OFF_W + STEP_W;

    localparam logic [7:0] OP_MOVEWORD = 8'hBC;
    localparam logic [7:0] OP_ENDDL    = 8'hB8;
    localparam logic [7:0] OP_FOGCOLOR = 8'hF8;
    localparam logic [7:0] OP_DL       = 8'h06;
    localparam logic [7:0] MW_SEGMENT  = 8'h06;
    localparam logic [7:0] MW_FOG      = 8'h08;
    localparam logic [31:0] FOG_MW_ONE  = 32'h64009D00;
    localparam logic [31:0] FOG_RGB_ONE = 32'h39303700;
    localparam logic [15:0] FOG_UNITY   = 16'd4096;

    localparam logic [0:0] CFG_MATCH = 1'b0;
    localparam logic [0:0] CFG_SCALE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_POP,
        ST_SCALE,
        ST_OUT,
        ST_PEEK
    } state_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] phys;
    } resolve_t;

    // q4.12 product to 16 bits, truncated toward zero then saturated
    function automatic logic [15:0] sat_half(input logic signed [32:0] p);
        logic signed [32:0] q;
        begin
            q = (p < 0) ? -((-p) >>> 12) : (p >>> 12);
            if (q > 33'sd32767)
                sat_half = 16'h7FFF;
            else if (q < -33'sd32768)
                sat_half = 16'h8000;
            else
                sat_half = q[15:0];
        end
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/dlfr_ram.sv
// generic simple dual port ram (separate write and read address) with registered read
`default_nettype none
module dlfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/dlfr_scaler.sv
// registered fog half scaler, multiply then shift and saturate
`default_nettype none
module dlfr_scaler (
    input  wire         aclk,
    input  wire  [31:0] word_in,
    input  wire  [15:0] scale,
    output logic [31:0] word_out
);
    import dlfr_pkg::*;
    logic signed [32:0] prod_hi_reg, prod_lo_reg;

    always_ff @(posedge aclk) begin
        prod_hi_reg <= 33'(signed'(word_in[31:16])) * 33'(signed'({1'b0, scale}));
        prod_lo_reg <= 33'(signed'(word_in[15:0])) * 33'(signed'({1'b0, scale}));
    end

    assign word_out = {sat_half(prod_hi_reg), sat_half(prod_lo_reg)};
endmodule
`default_nettype wire

// File: rtl/core/display_list_fog_rewriter.sv
// display list fog rewriter: sequencer over segment and return stack memories
// states: a start or command word goes read, exec, peek, pop, out; scaled fog has scale in place of peek;
// a command while the walk is idle goes read, exec, out; each level popped while settling adds peek, pop.
// the next input word is taken only back in idle, after the result is taken; one item at a time.
// segment valid bits clear on start and reset; the return stack has no reset.
// reset: synchronous active low aresetn, idle walk, registers at reset values.
`default_nettype none
module display_list_fog_rewriter (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_mode,
    input  wire  [31:0] s_start_address,
    input  wire  [31:0] s_word0,
    input  wire  [31:0] s_word1,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_new_word1,
    output logic        m_rewritten,
    output logic [22:0] m_fetch_offset,
    output logic        m_done_res,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [0:0]  cfg_index,
    input  wire  [31:0] cfg_data
);
    import dlfr_pkg::*;

    state_t state_reg, state_next;
    logic        match_reg;
    logic [15:0] scale_reg;
    logic        mode_reg;
    logic [31:0] addr_reg, w0_reg, w1_reg, w1_next;
    logic [SEGMENTS-1:0] segv_reg, segv_next;
    logic [OFF_W:0]     off_reg, off_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic        active_reg, active_next;
    logic [31:0] nw_reg, nw_next;
    logic        rew_reg, rew_next;

    logic seg_we, stk_we;
    logic [SEG_W-1:0] seg_waddr, seg_raddr;
    logic [31:0] seg_rdata;
    logic [DEPTH_W-1:0] stk_addr;
    logic [STK_W-1:0] stk_wdata, stk_rdata;
    logic [31:0] fog_src;
    logic [31:0] scaled;

    assign fog_src = match_reg ? FOG_MW_ONE : w1_reg;

    dlfr_ram #(.WIDTH(32), .DEPTH(SEGMENTS)) u_seg (
        .aclk(aclk), .we(seg_we), .waddr(seg_waddr), .wdata(w1_reg),
        .raddr(seg_raddr), .rdata(seg_rdata));
    dlfr_ram #(.WIDTH(STK_W), .DEPTH(MAX_DEPTH)) u_stk (
        .aclk(aclk), .we(stk_we), .waddr(stk_addr), .wdata(stk_wdata),
        .raddr(stk_addr), .rdata(stk_rdata));
    dlfr_scaler u_scl (.aclk(aclk), .word_in(fog_src), .scale(scale_reg), .word_out(scaled));

    logic [31:0] raddr_src;
    logic [7:0]  hi;
    logic [31:0] seg_val, phys;
    logic        res_ok;
    logic [7:0]  op, sub;
    logic [OFF_W:0] off_plus;

    assign raddr_src = mode_reg ? w1_reg : addr_reg;
    assign hi        = raddr_src[31:24];
    assign seg_raddr = state_reg == ST_IDLE ? (s_mode ? s_word1[27:24] : s_start_address[27:24])
                                            : raddr_src[27:24];
    assign seg_val   = segv_reg[raddr_src[27:24]] ? seg_rdata : 32'd0;
    always_comb begin
        phys   = 32'd0;
        res_ok = 1'b0;
        if (hi >= 8'h80 && hi <= 8'h9F) begin
            phys   = raddr_src & 32'h1FFFFFFF;
            res_ok = 1'b1;
        end else if (hi < 8'h10) begin
            phys   = (seg_val & 32'h1FFFFFFF) + (raddr_src & 32'h00FFFFFF);
            res_ok = 1'b1;
        end
        if (phys >= 32'(MEM_BYTES))
            res_ok = 1'b0;
    end
    assign op  = w0_reg[31:24];
    assign sub = w0_reg[7:0];
    assign off_plus = off_reg + (OFF_W+1)'(8);

    assign s_ready   = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_valid   = state_reg == ST_OUT;
    assign m_new_word1    = nw_reg;
    assign m_rewritten    = rew_reg;
    assign m_fetch_offset = active_reg ? off_reg[OFF_W-1:0] : '0;
    assign m_done_res     = ~active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            match_reg  <= 1'b0;
            scale_reg  <= FOG_UNITY;
            segv_reg   <= '0;
            off_reg    <= '0;
            step_reg   <= '0;
            depth_reg  <= '0;
            active_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            segv_reg   <= segv_next;
            off_reg    <= off_next;
            step_reg   <= step_next;
            depth_reg  <= depth_next;
            active_reg <= active_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_MATCH: match_reg <= cfg_data[0];
                    CFG_SCALE: scale_reg <= cfg_data[15:0];
                    default:   match_reg <= match_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        nw_reg  <= nw_next;
        rew_reg <= rew_next;
        w1_reg  <= w1_next;
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            addr_reg <= s_start_address;
            w0_reg   <= s_word0;
        end
    end

    always_comb begin
        state_next  = state_reg;
        segv_next   = segv_reg;
        off_next    = off_reg;
        step_next   = step_reg;
        depth_next  = depth_reg;
        active_next = active_reg;
        nw_next     = nw_reg;
        rew_next    = rew_reg;
        w1_next     = w1_reg;
        seg_we      = 1'b0;
        seg_waddr   = w0_reg[13:10];
        stk_we      = 1'b0;
        stk_addr    = depth_reg;
        stk_wdata   = {off_reg[OFF_W-1:0], step_reg};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    w1_next    = s_word1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // segment read lands here; stack read of the current top is issued here
                stk_addr   = depth_reg - DEPTH_W'(1);
                state_next = ST_EXEC;
                if (!mode_reg)
                    segv_next = '0;
            end
            ST_EXEC: begin
                nw_next    = w1_reg;
                rew_next   = 1'b0;
                state_next = ST_PEEK;
                stk_addr   = depth_reg - DEPTH_W'(1);
                if (!mode_reg) begin
                    nw_next     = 32'd0;
                    depth_next  = '0;
                    step_next   = '0;
                    active_next = res_ok;
                    off_next    = res_ok ? {1'b0, phys[OFF_W-1:0]} : '0;
                end else if (!active_reg) begin
                    state_next = ST_OUT;
                end else begin
                    priority if (op == OP_MOVEWORD) begin
                        off_next  = off_plus;
                        step_next = step_reg + STEP_W'(1);
                        if (sub == MW_SEGMENT) begin
                            seg_we    = 1'b1;
                            segv_next = segv_reg | (SEGMENTS'(1) << w0_reg[13:10]);
                        end else if (sub == MW_FOG) begin
                            rew_next = 1'b1;
                            nw_next  = fog_src;
                            if (scale_reg != FOG_UNITY)
                                state_next = ST_SCALE;
                        end
                    end else if (op == OP_FOGCOLOR) begin
                        off_next  = off_plus;
                        step_next = step_reg + STEP_W'(1);
                        if (match_reg) begin
                            nw_next  = FOG_RGB_ONE | {24'd0, w1_reg[7:0]};
                            rew_next = 1'b1;
                        end
                    end else if (op == OP_DL) begin
                        if (w0_reg[23:16] != 8'd0) begin
                            if (res_ok) begin
                                off_next  = {1'b0, phys[OFF_W-1:0]};
                                step_next = step_reg + STEP_W'(1);
                            end else if (depth_reg == '0) begin
                                active_next = 1'b0;
                            end else begin
                                depth_next = depth_reg - DEPTH_W'(1);
                                off_next   = {1'b0, stk_rdata[STK_W-1:STEP_W]}
                                             + (OFF_W+1)'(8);
                                step_next  = stk_rdata[STEP_W-1:0] + STEP_W'(1);
                            end
                        end else if (depth_reg < DEPTH_W'(MAX_DEPTH) && res_ok) begin
                            stk_we     = 1'b1;
                            stk_addr   = depth_reg;
                            depth_next = depth_reg + DEPTH_W'(1);
                            off_next   = {1'b0, phys[OFF_W-1:0]};
                            step_next  = '0;
                        end else begin
                            off_next  = off_plus;
                            step_next = step_reg + STEP_W'(1);
                        end
                    end else if (op == OP_ENDDL) begin
                        if (depth_reg == '0) begin
                            active_next = 1'b0;
                        end else begin
                            depth_next = depth_reg - DEPTH_W'(1);
                            off_next   = {1'b0, stk_rdata[STK_W-1:STEP_W]} + (OFF_W+1)'(8);
                            step_next  = stk_rdata[STEP_W-1:0] + STEP_W'(1);
                        end
                    end else begin
                        off_next  = off_plus;
                        step_next = step_reg + STEP_W'(1);
                    end
                end
            end
            ST_SCALE: begin
                nw_next    = scaled;
                state_next = ST_POP;
                stk_addr   = depth_reg - DEPTH_W'(1);
            end
            ST_PEEK: begin
                // stack read of the current top for the settle check
                stk_addr   = depth_reg - DEPTH_W'(1);
                state_next = ST_POP;
            end
            ST_POP: begin
                if (active_reg && (step_reg >= STEP_W'(STEP_LIMIT)
                        || off_plus > (OFF_W+1)'(MEM_BYTES))) begin
                    if (depth_reg == '0) begin
                        active_next = 1'b0;
                        state_next  = ST_OUT;
                    end else begin
                        depth_next = depth_reg - DEPTH_W'(1);
                        off_next   = {1'b0, stk_rdata[STK_W-1:STEP_W]} + (OFF_W+1)'(8);
                        step_next  = stk_rdata[STEP_W-1:0] + STEP_W'(1);
                        state_next = ST_PEEK;
                    end
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_word1))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(MAX_DEPTH))
        else $error("nesting depth beyond bound");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_done_res == !active_reg) && !s_ready)
        else $error("output and input both open");
endmodule
`default_nettype wire
